// ===== rtl/core/dfp_pkg.sv =====
`default_nettype none

package dfp_pkg;

  // Kinds of work that reach the conversion pipe.
  localparam logic [1:0] KIND_CHR = 2'd0;
  localparam logic [1:0] KIND_HEX = 2'd1;
  localparam logic [1:0] KIND_DEC = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LOW_D   = 8'h64;
  localparam logic [7:0] CH_LOW_I   = 8'h69;
  localparam logic [7:0] CH_LOW_C   = 8'h63;
  localparam logic [7:0] CH_UP_C    = 8'h43;

  // Reciprocal constants for division by 100 and by 10.
  localparam logic [12:0] RECIP_100_LO = 13'd5242;  // x/100 ~ x*5242 >> 19, may be one low
  localparam logic [5:0]  RECIP_100_SM = 6'd41;     // x/100 = x*41 >> 12 for x < 1000
  localparam logic [7:0]  RECIP_10     = 8'd205;    // x/10  = x*205 >> 11 for x < 1029

  localparam int unsigned NUM_CHARS = 5;

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [15:0] arg_value;
  } fmt_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } fmt_out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [15:0] val;
  } item_t;

  typedef struct packed {
    logic [NUM_CHARS-1:0][7:0] chars;
    logic [2:0]                last_idx;
  } job_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_UPPER_A + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

  // Splits a value below 100 into tens (upper nibble) and ones (lower nibble).
  function automatic logic [7:0] two_digits(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = {8'd0, x} * {7'd0, RECIP_10};
    t = p[14:11];
    o = x - ({3'd0, t} * 7'd10);
    return {t, o[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dfp_conv.sv =====
`default_nettype none

module dfp_conv (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          item_valid,
  input  wire dfp_pkg::item_t item,
  output logic               item_ready,
  input  wire logic          job_take,
  output logic               job_valid,
  output dfp_pkg::job_t      job
);

  logic           s1_v_r, s2_v_r, s3_v_r;
  dfp_pkg::item_t s1_r, s2_r, s3_r;
  logic [9:0]     s2_qe_r;
  logic [9:0]     s3_q_r;
  logic [6:0]     s3_rem_r;

  logic rdy1, rdy2, rdy3;

  logic [28:0] prod;
  logic [16:0] rem_full;
  logic [7:0]  rem8;
  logic [9:0]  q_fix;
  logic [6:0]  rem_fix;

  logic [15:0] hi_prod;
  logic [3:0]  d_top;
  logic [9:0]  q_rest;
  logic [7:0]  mid_pair;
  logic [7:0]  low_pair;

  assign rdy3 = job_take || !s3_v_r;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign item_ready = rdy1;

  // Quotient estimate by 100, corrected by one compare and subtract.
  assign prod     = {13'd0, s1_r.val} * {16'd0, dfp_pkg::RECIP_100_LO};
  assign rem_full = {1'b0, s2_r.val} - 17'({7'd0, s2_qe_r} * 17'd100);
  assign rem8     = rem_full[7:0];
  always_comb begin
    if (rem8 >= 8'd100) begin
      q_fix   = s2_qe_r + 10'd1;
      rem_fix = 7'(rem8 - 8'd100);
    end else begin
      q_fix   = s2_qe_r;
      rem_fix = rem8[6:0];
    end
  end

  assign hi_prod  = {6'd0, s3_q_r} * {10'd0, dfp_pkg::RECIP_100_SM};
  assign d_top    = hi_prod[15:12];
  assign q_rest   = s3_q_r - 10'({6'd0, d_top} * 10'd100);
  assign mid_pair = dfp_pkg::two_digits(q_rest[6:0]);
  assign low_pair = dfp_pkg::two_digits(s3_rem_r);

  always_comb begin
    job = '0;
    case (s3_r.kind)
      dfp_pkg::KIND_HEX: begin
        job.chars[0] = dfp_pkg::hex_ascii(s3_r.val[15:12]);
        job.chars[1] = dfp_pkg::hex_ascii(s3_r.val[11:8]);
        job.chars[2] = dfp_pkg::hex_ascii(s3_r.val[7:4]);
        job.chars[3] = dfp_pkg::hex_ascii(s3_r.val[3:0]);
        job.last_idx = 3'd3;
      end
      dfp_pkg::KIND_DEC: begin
        job.chars[0] = dfp_pkg::CH_ZERO + {4'd0, d_top};
        job.chars[1] = dfp_pkg::CH_ZERO + {4'd0, mid_pair[7:4]};
        job.chars[2] = dfp_pkg::CH_ZERO + {4'd0, mid_pair[3:0]};
        job.chars[3] = dfp_pkg::CH_ZERO + {4'd0, low_pair[7:4]};
        job.chars[4] = dfp_pkg::CH_ZERO + {4'd0, low_pair[3:0]};
        job.last_idx = 3'd4;
      end
      default: begin
        job.chars[0] = s3_r.ch;
        job.last_idx = 3'd0;
      end
    endcase
  end

  assign job_valid = s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= item_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= item;
    end
    if (rdy2) begin
      s2_r    <= s1_r;
      s2_qe_r <= prod[28:19];
    end
    if (rdy3) begin
      s3_r     <= s2_r;
      s3_q_r   <= q_fix;
      s3_rem_r <= rem_fix;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/debug_format_printer.sv =====
`default_nettype none

// Channel   Direction  Word        Handshake
// in_       input      fmt_in_t    in_valid / in_stall
// out_      output     fmt_out_t   out_valid / out_stall
//
// A new format word can be accepted in every cycle while in_stall is low. A word that prints
// passes three register stages (s1, s2, s3) into the output buffer. The output sends one
// character per cycle while out_stall is low (one for a plain or %c word, four for %x, five
// for %d), and that count sets the sustained rate. Reset (synchronous, active low) clears
// the pending-percent flag and all valid bits. An output stall holds the current character
// and backs up the stages one at a time until in_stall rises.

module debug_format_printer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire dfp_pkg::fmt_in_t in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output dfp_pkg::fmt_out_t     out_data,
  input  wire logic             out_stall
);

  // Set by a '%' and cleared by the word after it or by a terminating zero.
  logic percent_pending_r, percent_pending_nxt;

  logic           in_fire;
  logic           item_valid;
  logic           item_ready;
  dfp_pkg::item_t item;

  logic          job_valid;
  logic          job_take;
  dfp_pkg::job_t job;

  // Output buffer: the characters of one word, sent one per cycle while out_stall is low.
  logic                                 job_v_r;
  logic [dfp_pkg::NUM_CHARS-1:0][7:0]   chars_r;
  logic [2:0]                           last_r;
  logic [2:0]                           pos_r;

  logic out_fire;
  logic at_last;

  assign in_stall = !item_ready;
  assign in_fire  = in_valid && item_ready;

  // Decode the format word against the pending flag. Words that produce no
  // characters (a '%', a terminating zero, an unknown conversion) update the
  // flag and go no further.
  always_comb begin
    percent_pending_nxt = percent_pending_r;
    item_valid          = 1'b0;
    item.kind           = dfp_pkg::KIND_CHR;
    item.ch             = in_data.fmt_char;
    item.val            = in_data.arg_value;
    if (in_valid) begin
      if (in_data.fmt_char == dfp_pkg::CH_NUL) begin
        percent_pending_nxt = 1'b0;
      end else if (!percent_pending_r) begin
        if (in_data.fmt_char == dfp_pkg::CH_PERCENT) begin
          percent_pending_nxt = 1'b1;
        end else begin
          item_valid = 1'b1;
        end
      end else begin
        percent_pending_nxt = 1'b0;
        if (in_data.fmt_char inside {dfp_pkg::CH_LOW_X, dfp_pkg::CH_UP_X}) begin
          item_valid = 1'b1;
          item.kind  = dfp_pkg::KIND_HEX;
        end else if (in_data.fmt_char inside {dfp_pkg::CH_LOW_D, dfp_pkg::CH_LOW_I}) begin
          item_valid = 1'b1;
          item.kind  = dfp_pkg::KIND_DEC;
        end else if (in_data.fmt_char inside {dfp_pkg::CH_LOW_C, dfp_pkg::CH_UP_C}) begin
          item_valid = 1'b1;
          item.ch    = in_data.arg_value[7:0];
        end
      end
    end
  end

  dfp_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .job_take   (job_take),
    .job_valid  (job_valid),
    .job        (job)
  );

  assign at_last   = (pos_r == last_r);
  assign out_fire  = job_v_r && !out_stall;
  // The buffer takes a new word when empty or when its last character leaves.
  assign job_take  = !job_v_r || (out_fire && at_last);

  assign out_valid            = job_v_r;
  assign out_data.out_char    = chars_r[pos_r];
  assign out_data.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      percent_pending_r <= 1'b0;
      job_v_r           <= 1'b0;
      pos_r             <= 3'd0;
    end else begin
      if (in_fire) begin
        percent_pending_r <= percent_pending_nxt;
      end
      if (job_take) begin
        job_v_r <= job_valid;
        pos_r   <= 3'd0;
      end else if (out_fire) begin
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      chars_r <= job.chars;
      last_r  <= job.last_idx;
    end
  end

endmodule

`default_nettype wire

// ===== bench/dfp_checker.sv =====
`timescale 1ns / 100ps

module dfp_checker
  import dfp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire fmt_in_t  in_data,
  input  wire logic     in_stall,
  input  wire logic     out_valid,
  input  wire fmt_out_t out_data,
  input  wire logic     out_stall,
  output int            fail_count,
  output int            chars_pending,
  output int            words_seen,
  output int            chars_checked
);

  logic     pct_pending;
  fmt_out_t expected_chars [$];

  initial begin
    fail_count    = 0;
    chars_pending = 0;
    words_seen    = 0;
    chars_checked = 0;
    pct_pending   = 1'b0;
  end

  function automatic logic [7:0] nibble_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = CH_ZERO + 8'(d);
    end else begin
      g = CH_UPPER_A + 8'(d) - 8'd10;
    end
    return g;
  endfunction

  // Expands one format word into the characters it should print.
  function automatic void expand_word(input fmt_in_t w);
    logic [7:0]  run [$];
    int unsigned v;
    fmt_out_t    c;
    v = w.arg_value;
    if (w.fmt_char == CH_NUL) begin
      pct_pending = 1'b0;
    end else if (!pct_pending) begin
      if (w.fmt_char == CH_PERCENT) begin
        pct_pending = 1'b1;
      end else begin
        run.push_back(w.fmt_char);
      end
    end else begin
      pct_pending = 1'b0;
      case (w.fmt_char)
        CH_LOW_X, CH_UP_X: begin
          for (int s = 12; s >= 0; s -= 4) run.push_back(nibble_glyph(4'(v >> s)));
        end
        CH_LOW_D, CH_LOW_I: begin
          for (int p = 10000; p >= 1; p /= 10) run.push_back(CH_ZERO + 8'((v / p) % 10));
        end
        CH_LOW_C, CH_UP_C: begin
          run.push_back(w.arg_value[7:0]);
        end
        default: begin
        end
      endcase
    end
    foreach (run[k]) begin
      c.out_char    = run[k];
      c.last_of_run = (k == run.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    fmt_out_t exp_c;
    if (!rst_n) begin
      pct_pending = 1'b0;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character, expected none, got %02h last=%0b",
                   $time, out_data.out_char, out_data.last_of_run);
          fail_count++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (out_data.out_char !== exp_c.out_char) begin
            $display("%0t: out_char mismatch, expected %02h, got %02h",
                     $time, exp_c.out_char, out_data.out_char);
            fail_count++;
          end
          if (out_data.last_of_run !== exp_c.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                     $time, exp_c.last_of_run, out_data.last_of_run);
            fail_count++;
          end
        end
        chars_checked++;
      end
      if (in_valid && !in_stall) begin
        expand_word(in_data);
        words_seen++;
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

// ===== bench/debug_format_printer_tb.sv =====
`timescale 1ns / 100ps

module debug_format_printer_tb;
  import dfp_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  fmt_in_t  in_data;
  logic     in_stall;
  logic     out_valid;
  fmt_out_t out_data;
  logic     out_stall;

  int fail_count;
  int chars_pending;
  int words_seen;
  int chars_checked;

  // Idling switches for the sender and the receiver, flipped by the stimulus
  // so that some stretches run back to back and the tail runs with no gaps.
  logic in_idle_on;
  logic out_idle_on;
  int   sent;

  debug_format_printer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  dfp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .words_seen    (words_seen),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver stalls in bursts of random length while its idling is on.
  // A burst in progress always runs out, even if idling is switched off.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic fmt_in_t make_word(input logic [7:0] c, input logic [15:0] a);
    fmt_in_t w;
    w.fmt_char  = c;
    w.arg_value = a;
    return w;
  endfunction

  // Arguments lean toward the extremes now and then so that all-zero and
  // all-ones digits show up often.
  function automatic logic [15:0] pick_arg();
    logic [15:0] a;
    case ($urandom_range(0, 7))
      0:       a = 16'h0000;
      1:       a = 16'hFFFF;
      2:       a = 16'($urandom_range(0, 255));
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  function automatic logic [7:0] pick_spec();
    logic [7:0] s;
    case ($urandom_range(0, 5))
      0:       s = CH_LOW_X;
      1:       s = CH_UP_X;
      2:       s = CH_LOW_D;
      3:       s = CH_LOW_I;
      4:       s = CH_LOW_C;
      default: s = CH_UP_C;
    endcase
    return s;
  endfunction

  // A plain character: any nonzero byte except the percent sign.
  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == CH_PERCENT) begin
      c = 8'($urandom_range(CH_PERCENT + 1, 255));
    end
    return c;
  endfunction

  // Presents one word at the falling edge, optionally after an idle burst,
  // and returns once the block has taken it.
  task automatic send_word(input fmt_in_t w);
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_conversion(input logic [7:0] spec, input logic [15:0] a);
    send_word(make_word(CH_PERCENT, pick_arg()));
    send_word(make_word(spec, a));
  endtask

  // Stops offering words and waits until every expected character is out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    sent        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: plain extremes, every specifier at argument extremes,
    // a %c whose low byte is zero, a doubled percent, an unknown specifier,
    // a string that ends right after a percent, and a bare end of string.
    send_word(make_word(8'h41, 16'h5A5A));
    send_word(make_word(8'hFF, 16'hFFFF));
    send_word(make_word(8'h01, 16'h0000));
    send_conversion(CH_LOW_X, 16'h0000);
    send_conversion(CH_UP_X, 16'hFFFF);
    send_conversion(CH_LOW_D, 16'h0000);
    send_conversion(CH_LOW_I, 16'hFFFF);
    send_conversion(CH_LOW_D, 16'd10009);
    send_conversion(CH_LOW_C, 16'h1200);
    send_conversion(CH_UP_C, 16'hABFF);
    send_conversion(CH_PERCENT, 16'h1234);
    send_conversion(8'h71, 16'h8000);
    send_conversion(CH_NUL, 16'h00FF);
    send_word(make_word(CH_NUL, 16'hFFFF));

    // Let the block run completely dry once before the random part.
    drain();

    // Random part: mostly well-formed text and conversions, with some
    // broken conversions, string ends and raw bytes mixed in.
    while (sent < 372) begin
      in_idle_on  = (sent < 150) || (sent >= 210 && sent < 310);
      out_idle_on = (sent < 140) || (sent >= 220 && sent < 305);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_word(make_word(pick_plain(), pick_arg()));
      end else if (pick < 75) begin
        send_conversion(pick_spec(), pick_arg());
      end else if (pick < 85) begin
        send_conversion(8'($urandom_range(0, 255)), pick_arg());
      end else if (pick < 92) begin
        send_word(make_word(CH_NUL, pick_arg()));
      end else begin
        send_word(make_word(8'($urandom_range(0, 255)), pick_arg()));
      end
    end

    drain();
    repeat (20) @(negedge clk);

    $display("Run covered %0d format words and %0d output characters:", words_seen,
             chars_checked);
    $display("  plain text, hex/decimal/char conversions, bad specifiers, string ends.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
